// ===== rtl/core/bqcd_pkg.sv =====
package bqcd_pkg;

  localparam int unsigned COEF_FRAC_BITS_DEF = 30;
  localparam int unsigned Q_FRAC_BITS_DEF    = 8;

  localparam int unsigned FX_BITS   = 30;
  localparam int unsigned NUM_TERMS = 7;
  localparam int unsigned PI_LO_W   = 17;
  localparam logic [33:0] PI_Q32    = 34'd13493037705;
  localparam logic [31:0] FX_ONE    = 32'd1 << FX_BITS;

  typedef enum logic [1:0] {
    KIND_LOWPASS  = 2'd0,
    KIND_BANDPASS = 2'd1,
    KIND_HIGHPASS = 2'd2,
    KIND_INVALID  = 2'd3
  } kind_e;

  typedef struct packed {
    logic [1:0]  filter_kind;
    logic [17:0] cutoff_hz;
    logic [17:0] sample_rate_hz;
    logic [15:0] quality_q8;
  } in_t;

  typedef struct packed {
    logic signed [31:0] coef_b0;
    logic signed [31:0] coef_b1;
    logic signed [31:0] coef_b2;
    logic signed [31:0] coef_a1;
    logic signed [31:0] coef_a2;
    logic               error_flag;
  } out_t;

  typedef struct packed {
    logic        err;
    logic [1:0]  kind;
    logic [15:0] qual;
    logic        cneg;
  } ctx_t;

  typedef struct packed {
    ctx_t               ctx;
    logic [30:0]        x;
    logic [31:0]        x2;
    logic signed [31:0] ts;
    logic signed [31:0] tc;
    logic [31:0]        vs;
    logic [31:0]        vc;
    logic [31:0]        qs;
    logic [31:0]        qc;
  } hor_t;

  typedef struct packed {
    ctx_t               ctx;
    logic [30:0]        s;
    logic signed [31:0] c;
  } sc_t;

  function automatic logic [31:0] sat_pos(input logic [31:0] q);
    return q[31] ? 32'h7fff_ffff : q;
  endfunction

  function automatic logic [31:0] sat_neg(input logic [31:0] q);
    return (q > 32'h8000_0000) ? 32'h8000_0000 : (32'd0 - q);
  endfunction

endpackage

// ===== rtl/core/bqcd_div.sv =====
module bqcd_div #(
  parameter int unsigned NW = 8,
  parameter int unsigned DW = 8,
  parameter int unsigned QW = 8,
  parameter int unsigned SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [QW-1:0] quot_o,
  output logic [SW-1:0] side_o
);

  logic          vld_q  [QW];
  logic [DW-1:0] rem_q  [QW];
  logic [QW-1:0] sh_q   [QW];
  logic [DW-1:0] den_q  [QW];
  logic [SW-1:0] side_q [QW];
  logic [NW-1:0] num_hi;

  assign num_hi = num_i >> QW;

  for (genvar gi = 0; gi < QW; gi++) begin : g_stg
    logic          v_in;
    logic [DW-1:0] rem_in;
    logic [QW-1:0] sh_in;
    logic [DW-1:0] den_in;
    logic [SW-1:0] side_in;
    logic [DW:0]   trial;
    logic [DW:0]   diff;

    if (gi == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = DW'(num_hi);
      assign sh_in   = QW'(num_i);
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = vld_q[gi-1];
      assign rem_in  = rem_q[gi-1];
      assign sh_in   = sh_q[gi-1];
      assign den_in  = den_q[gi-1];
      assign side_in = side_q[gi-1];
    end

    assign trial = {rem_in, sh_in[QW-1]};
    assign diff  = trial - {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[gi] <= 1'b0;
      end else if (en_i) begin
        vld_q[gi] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!diff[DW]) begin
          rem_q[gi] <= diff[DW-1:0];
          sh_q[gi]  <= {sh_in[QW-2:0], 1'b1};
        end else begin
          rem_q[gi] <= trial[DW-1:0];
          sh_q[gi]  <= {sh_in[QW-2:0], 1'b0};
        end
        den_q[gi]  <= den_in;
        side_q[gi] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[QW-1];
  assign quot_o  = sh_q[QW-1];
  assign side_o  = side_q[QW-1];

endmodule

// ===== rtl/core/biquad_coefficient_designer_top.sv =====
// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i / in_stall_o   in_data_i  (bqcd_pkg::in_t)
// out       output     out_valid_o / out_stall_i out_data_o (bqcd_pkg::out_t)
//
// One transaction per cycle sustained while the output is not stalled. Pipeline
// depth is set by the phase, alpha and coefficient dividers (one quotient bit per
// stage) and the seven-term sine/cosine series (three stages per term).
// Reset clears all valid bits; data registers are not reset.
// An output stall freezes the pipeline; the input stage still fills one empty slot.
module biquad_coefficient_designer_top #(
  parameter int unsigned COEF_FRAC_BITS = bqcd_pkg::COEF_FRAC_BITS_DEF,
  parameter int unsigned Q_FRAC_BITS    = bqcd_pkg::Q_FRAC_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  bqcd_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output bqcd_pkg::out_t out_data_o
);

  localparam int unsigned AN_W = 31 + Q_FRAC_BITS;
  localparam int unsigned A0_W = 32 + Q_FRAC_BITS;
  localparam int unsigned CD_W = A0_W + 2;
  localparam int unsigned CN_W = 34 + COEF_FRAC_BITS;
  localparam int unsigned HN   = 3 * bqcd_pkg::NUM_TERMS;

  logic en, ld0;
  logic v0_q;
  logic out_valid_q;
  bqcd_pkg::out_t out_q;

  assign en  = !out_valid_q || !out_stall_i;
  assign ld0 = en || !v0_q;
  assign in_stall_o = !ld0;

  // input stage
  bqcd_pkg::in_t in_q;
  bqcd_pkg::ctx_t ctx0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (ld0) begin
      v0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld0) begin
      in_q <= in_data_i;
    end
  end

  always_comb begin
    ctx0.kind = in_q.filter_kind;
    ctx0.qual = in_q.quality_q8;
    ctx0.cneg = 1'b0;
    ctx0.err  = (in_q.filter_kind == bqcd_pkg::KIND_INVALID) || (in_q.quality_q8 == 16'd0) ||
                (in_q.sample_rate_hz == 18'd0) ||
                ({in_q.cutoff_hz, 1'b0} >= {1'b0, in_q.sample_rate_hz});
  end

  // phase = f0 * 2^32 / fs
  logic           vp;
  logic [30:0]    phase;
  bqcd_pkg::ctx_t ctx_p;

  bqcd_div #(
    .NW(50), .DW(19), .QW(31), .SW($bits(bqcd_pkg::ctx_t))
  ) u_div_phase (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v0_q),
    .num_i   ({in_q.cutoff_hz, 32'd0}),
    .den_i   ({1'b0, in_q.sample_rate_hz}),
    .side_i  (ctx0),
    .valid_o (vp),
    .quot_o  (phase),
    .side_o  (ctx_p)
  );

  // fold and angle
  logic           f1_v_q, f2_v_q, f3_v_q, f4_v_q;
  logic [30:0]    f1_r_q;
  bqcd_pkg::ctx_t f1_ctx_q, f2_ctx_q, f3_ctx_q, f4_ctx_q;
  bqcd_pkg::ctx_t ctx_f;
  logic [47:0]    f2_pl_q, f2_ph_q;
  logic [30:0]    f3_x_q, f4_x_q;
  logic [31:0]    f4_x2_q;
  logic [30:0]    r_d;
  logic [31:0]    r_fold;
  logic [65:0]    f3_sum;
  logic [61:0]    f4_sq;

  assign r_fold = (32'd1 << 31) - {1'b0, phase};
  assign r_d    = phase[30] ? r_fold[30:0] : phase;
  assign f3_sum = (66'(f2_ph_q) << bqcd_pkg::PI_LO_W) + 66'(f2_pl_q) + (66'd1 << 32);
  assign f4_sq  = 62'(f3_x_q) * 62'(f3_x_q);

  always_comb begin
    ctx_f      = ctx_p;
    ctx_f.cneg = phase[30];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_v_q <= 1'b0;
      f2_v_q <= 1'b0;
      f3_v_q <= 1'b0;
      f4_v_q <= 1'b0;
    end else if (en) begin
      f1_v_q <= vp;
      f2_v_q <= f1_v_q;
      f3_v_q <= f2_v_q;
      f4_v_q <= f3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f1_r_q   <= r_d;
      f1_ctx_q <= ctx_f;
      f2_pl_q  <= 48'(f1_r_q) * 48'(bqcd_pkg::PI_Q32[bqcd_pkg::PI_LO_W-1:0]);
      f2_ph_q  <= 48'(f1_r_q) * 48'(bqcd_pkg::PI_Q32[33:bqcd_pkg::PI_LO_W]);
      f2_ctx_q <= f1_ctx_q;
      f3_x_q   <= f3_sum[63:33];
      f3_ctx_q <= f2_ctx_q;
      f4_x_q   <= f3_x_q;
      f4_x2_q  <= f4_sq[61:30];
      f4_ctx_q <= f3_ctx_q;
    end
  end

  // sine and cosine series
  bqcd_pkg::hor_t h_in;
  bqcd_pkg::hor_t hor_q [HN];
  logic           hv_q  [HN];

  always_comb begin
    h_in     = '0;
    h_in.ctx = f4_ctx_q;
    h_in.x   = f4_x_q;
    h_in.x2  = f4_x2_q;
    h_in.ts  = bqcd_pkg::FX_ONE;
    h_in.tc  = bqcd_pkg::FX_ONE;
  end

  for (genvar gi = 0; gi < bqcd_pkg::NUM_TERMS; gi++) begin : g_term
    localparam int unsigned K  = bqcd_pkg::NUM_TERMS - gi;
    localparam int unsigned DS = 2 * K * (2 * K + 1);
    localparam int unsigned DC = (2 * K - 1) * (2 * K);
    localparam logic [31:0] MS = 32'((64'd1 << 32) / DS);
    localparam logic [31:0] MC = 32'((64'd1 << 32) / DC);

    bqcd_pkg::hor_t a_in, a_d, b_d, c_d;
    logic           a_vin;
    logic [62:0]    ps, pc;
    logic [63:0]    ms, mc;
    logic [31:0]    rs, rc, qs_fix, qc_fix;

    if (gi == 0) begin : g_head
      assign a_in  = h_in;
      assign a_vin = f4_v_q;
    end else begin : g_link
      assign a_in  = hor_q[3*gi-1];
      assign a_vin = hv_q[3*gi-1];
    end

    assign ps = 63'(a_in.x2) * 63'(a_in.ts[30:0]);
    assign pc = 63'(a_in.x2) * 63'(a_in.tc[30:0]);
    assign ms = 64'(hor_q[3*gi].vs) * 64'(MS);
    assign mc = 64'(hor_q[3*gi].vc) * 64'(MC);
    assign rs = hor_q[3*gi+1].vs - hor_q[3*gi+1].qs * 32'(DS);
    assign rc = hor_q[3*gi+1].vc - hor_q[3*gi+1].qc * 32'(DC);
    assign qs_fix = hor_q[3*gi+1].qs + 32'(rs >= 32'(DS));
    assign qc_fix = hor_q[3*gi+1].qc + 32'(rc >= 32'(DC));

    always_comb begin
      a_d    = a_in;
      a_d.vs = ps[61:30];
      a_d.vc = pc[61:30];
      b_d    = hor_q[3*gi];
      b_d.qs = ms[63:32];
      b_d.qc = mc[63:32];
      c_d    = hor_q[3*gi+1];
      c_d.ts = bqcd_pkg::FX_ONE - qs_fix;
      c_d.tc = bqcd_pkg::FX_ONE - qc_fix;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        hv_q[3*gi]   <= 1'b0;
        hv_q[3*gi+1] <= 1'b0;
        hv_q[3*gi+2] <= 1'b0;
      end else if (en) begin
        hv_q[3*gi]   <= a_vin;
        hv_q[3*gi+1] <= hv_q[3*gi];
        hv_q[3*gi+2] <= hv_q[3*gi+1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        hor_q[3*gi]   <= a_d;
        hor_q[3*gi+1] <= b_d;
        hor_q[3*gi+2] <= c_d;
      end
    end
  end

  // sine product, clamps
  logic               z1_v_q, z2_v_q;
  logic [31:0]        z1_s_q;
  logic signed [31:0] z1_c_q;
  bqcd_pkg::ctx_t     z1_ctx_q;
  bqcd_pkg::sc_t      z2_q;
  logic [61:0]        sm;
  logic [30:0]        s_d;
  logic [30:0]        c_abs;
  logic signed [31:0] c_d;

  assign sm = 62'(hor_q[HN-1].x) * 62'(hor_q[HN-1].ts[30:0]);

  always_comb begin
    s_d = (z1_s_q > bqcd_pkg::FX_ONE) ? bqcd_pkg::FX_ONE[30:0] : z1_s_q[30:0];
    if (z1_c_q < 0) begin
      c_abs = '0;
    end else if (z1_c_q > $signed(bqcd_pkg::FX_ONE)) begin
      c_abs = bqcd_pkg::FX_ONE[30:0];
    end else begin
      c_abs = z1_c_q[30:0];
    end
    c_d = z1_ctx_q.cneg ? (32'sd0 - $signed({1'b0, c_abs})) : $signed({1'b0, c_abs});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      z1_v_q <= 1'b0;
      z2_v_q <= 1'b0;
    end else if (en) begin
      z1_v_q <= hv_q[HN-1];
      z2_v_q <= z1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      z1_s_q   <= sm[61:30];
      z1_c_q   <= hor_q[HN-1].tc;
      z1_ctx_q <= hor_q[HN-1].ctx;
      z2_q     <= '{ctx: z1_ctx_q, s: s_d, c: c_d};
    end
  end

  // alpha = (s * 2^QF + Q) / (2 Q)
  logic            va;
  logic [AN_W-1:0] alpha;
  bqcd_pkg::sc_t   sc_a;

  bqcd_div #(
    .NW(AN_W), .DW(17), .QW(AN_W), .SW($bits(bqcd_pkg::sc_t))
  ) u_div_alpha (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (z2_v_q),
    .num_i   ((AN_W'(z2_q.s) << Q_FRAC_BITS) + AN_W'(z2_q.ctx.qual)),
    .den_i   ({1'b0, z2_q.ctx.qual} << 1),
    .side_i  (z2_q),
    .valid_o (va),
    .quot_o  (alpha),
    .side_o  (sc_a)
  );

  // numerator magnitudes and a0
  logic             g_v_q, h_v_q;
  logic [A0_W-1:0]  g_a0_q;
  logic [31:0]      g_b0m_q, g_b1m_q, g_a1m_q;
  logic             g_b1neg_q, g_a1neg_q;
  bqcd_pkg::ctx_t   g_ctx_q;
  logic signed [32:0] c33;
  logic [32:0]      om;
  logic [31:0]      cab2;

  assign c33  = {sc_a.c[31], sc_a.c};
  assign om   = (sc_a.ctx.kind == bqcd_pkg::KIND_HIGHPASS) ?
                33'(33'sd0 + $signed({1'b0, bqcd_pkg::FX_ONE}) + c33) :
                33'(33'sd0 + $signed({1'b0, bqcd_pkg::FX_ONE}) - c33);
  assign cab2 = sc_a.c[31] ? ((32'd0 - sc_a.c) << 1) : (sc_a.c << 1);

  logic [CN_W-1:0] h_nb0_q, h_nb1_q, h_na1_q, h_na2_q;
  logic [CD_W-1:0] h_db0_q, h_db1_q;
  logic            h_b1neg_q, h_a1neg_q;
  bqcd_pkg::ctx_t  h_ctx_q;
  logic [CD_W-1:0] d2a0, d1a0;

  assign d2a0 = CD_W'(g_a0_q) << 1;
  assign d1a0 = CD_W'(g_a0_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_v_q <= 1'b0;
      h_v_q <= 1'b0;
    end else if (en) begin
      g_v_q <= va;
      h_v_q <= g_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      g_a0_q    <= A0_W'(alpha) + (A0_W'(1) << bqcd_pkg::FX_BITS);
      g_b0m_q   <= (sc_a.ctx.kind == bqcd_pkg::KIND_BANDPASS) ? 32'(sc_a.s) : om[31:0];
      g_b1m_q   <= om[31:0];
      g_a1m_q   <= cab2;
      g_b1neg_q <= (sc_a.ctx.kind == bqcd_pkg::KIND_HIGHPASS);
      g_a1neg_q <= !sc_a.c[31] && (sc_a.c != 32'sd0);
      g_ctx_q   <= sc_a.ctx;
      h_nb0_q   <= (CN_W'(g_b0m_q) << (COEF_FRAC_BITS + 1)) + CN_W'(d2a0);
      h_nb1_q   <= (CN_W'(g_b1m_q) << (COEF_FRAC_BITS + 1)) + CN_W'(d1a0);
      h_na1_q   <= (CN_W'(g_a1m_q) << (COEF_FRAC_BITS + 1)) + CN_W'(d1a0);
      h_na2_q   <= (CN_W'(32'd1 << 31) << (COEF_FRAC_BITS + 1)) + CN_W'(d1a0);
      h_db0_q   <= d2a0 << 1;
      h_db1_q   <= d1a0 << 1;
      h_b1neg_q <= g_b1neg_q;
      h_a1neg_q <= g_a1neg_q;
      h_ctx_q   <= g_ctx_q;
    end
  end

  // rounded quotients
  logic        vb0, vb1, va1, va2;
  logic [31:0] qb0, qb1, qa1, qa2;
  logic [1:0]  kind_o;
  logic        b1neg_o, a1neg_o, err_o;

  bqcd_div #(.NW(CN_W), .DW(CD_W), .QW(32), .SW(2)) u_div_b0 (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en), .valid_i(h_v_q),
    .num_i(h_nb0_q), .den_i(h_db0_q), .side_i(h_ctx_q.kind),
    .valid_o(vb0), .quot_o(qb0), .side_o(kind_o)
  );

  bqcd_div #(.NW(CN_W), .DW(CD_W), .QW(32), .SW(1)) u_div_b1 (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en), .valid_i(h_v_q),
    .num_i(h_nb1_q), .den_i(h_db1_q), .side_i(h_b1neg_q),
    .valid_o(vb1), .quot_o(qb1), .side_o(b1neg_o)
  );

  bqcd_div #(.NW(CN_W), .DW(CD_W), .QW(32), .SW(1)) u_div_a1 (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en), .valid_i(h_v_q),
    .num_i(h_na1_q), .den_i(h_db1_q), .side_i(h_a1neg_q),
    .valid_o(va1), .quot_o(qa1), .side_o(a1neg_o)
  );

  bqcd_div #(.NW(CN_W), .DW(CD_W), .QW(32), .SW(1)) u_div_a2 (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en), .valid_i(h_v_q),
    .num_i(h_na2_q), .den_i(h_db1_q), .side_i(h_ctx_q.err),
    .valid_o(va2), .quot_o(qa2), .side_o(err_o)
  );

  // sign, saturation, error
  bqcd_pkg::out_t res;
  logic [31:0]    b0v;

  always_comb begin
    b0v = bqcd_pkg::sat_pos(qb0);
    res = '0;
    if (err_o) begin
      res.error_flag = 1'b1;
    end else begin
      res.coef_b0 = b0v;
      if (kind_o == bqcd_pkg::KIND_BANDPASS) begin
        res.coef_b1 = '0;
        res.coef_b2 = bqcd_pkg::sat_neg(qb0);
      end else begin
        res.coef_b1 = b1neg_o ? bqcd_pkg::sat_neg(qb1) : bqcd_pkg::sat_pos(qb1);
        res.coef_b2 = b0v;
      end
      res.coef_a1 = a1neg_o ? bqcd_pkg::sat_neg(qa1) : bqcd_pkg::sat_pos(qa1);
      res.coef_a2 = bqcd_pkg::sat_pos(qa2) - 32'(64'd1 << COEF_FRAC_BITS);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vb0 && vb1 && va1 && va2;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== test/biquad_coefficient_designer_checker.sv =====
module biquad_coefficient_designer_checker
  import bqcd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_stall_i,
  input  in_t  in_data_i,
  input  logic out_valid_i,
  input  logic out_stall_i,
  input  out_t out_data_i,
  output int   fail_count_o,
  output int   pending_o,
  output int   results_o
);

  localparam int CFB = 30;
  localparam int QFB = 8;
  localparam longint ONE = longint'(1) << 30;

  out_t coef_q[$];

  function automatic longint q30_mul(longint a, longint b);
    return (a * b) / ONE;
  endfunction

  function automatic logic [31:0] ratio_q(longint n, longint d);
    logic neg;
    longint unsigned mag, q;
    longint v;
    neg = n < 0;
    mag = neg ? longint'(-n) : n;
    q = ((mag << CFB) * 2 + d) / (2 * d);
    if (neg) v = (q > 64'd2147483648) ? -64'sd2147483648 : -longint'(q);
    else v = (q > 64'd2147483647) ? 64'sd2147483647 : longint'(q);
    return v[31:0];
  endfunction

  function automatic out_t design_coefs(in_t d);
    out_t o;
    longint unsigned f0, fs, qv, p, r, xu;
    longint x, x2, t, s, c, alpha, a0, opm;
    logic cneg;
    logic [31:0] two;
    o = '0;
    f0 = d.cutoff_hz;
    fs = d.sample_rate_hz;
    qv = d.quality_q8;
    if (kind_e'(d.filter_kind) == KIND_INVALID || qv == 0 || fs == 0 || 2 * f0 >= fs) begin
      o.error_flag = 1'b1;
      return o;
    end
    p = (f0 << 32) / fs;
    cneg = p >= (64'd1 << 30);
    r = cneg ? ((64'd1 << 31) - p) : p;
    xu = (r * 64'd13493037705 + (64'd1 << 32)) >> 33;
    x = xu;
    x2 = q30_mul(x, x);
    t = ONE;
    for (int k = 7; k >= 1; k--) t = ONE - q30_mul(x2, t) / ((2 * k) * (2 * k + 1));
    s = q30_mul(x, t);
    t = ONE;
    for (int k = 7; k >= 1; k--) t = ONE - q30_mul(x2, t) / ((2 * k - 1) * (2 * k));
    c = t;
    if (s < 0) s = 0;
    if (s > ONE) s = ONE;
    if (c < 0) c = 0;
    if (c > ONE) c = ONE;
    if (cneg) c = -c;
    alpha = ((longint'(s) << QFB) + qv) / (2 * qv);
    a0 = ONE + alpha;
    case (kind_e'(d.filter_kind))
      KIND_LOWPASS: begin
        opm = ONE - c;
        o.coef_b0 = ratio_q(opm, 2 * a0);
        o.coef_b1 = ratio_q(opm, a0);
        o.coef_b2 = o.coef_b0;
      end
      KIND_BANDPASS: begin
        o.coef_b0 = ratio_q(s, 2 * a0);
        o.coef_b1 = '0;
        o.coef_b2 = ratio_q(-s, 2 * a0);
      end
      default: begin
        opm = ONE + c;
        o.coef_b0 = ratio_q(opm, 2 * a0);
        o.coef_b1 = ratio_q(-opm, a0);
        o.coef_b2 = o.coef_b0;
      end
    endcase
    o.coef_a1 = ratio_q(-2 * c, a0);
    two = ratio_q(2 * ONE, a0);
    o.coef_a2 = two - (32'd1 << CFB);
    return o;
  endfunction

  assign pending_o = coef_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    out_t e;
    if (!rst_ni) begin
      fail_count_o <= 0;
      results_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) coef_q.push_back(design_coefs(in_data_i));
      if (out_valid_i && !out_stall_i) begin
        results_o <= results_o + 1;
        if (coef_q.size() == 0) begin
          $error("unexpected transaction %p", out_data_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          e = coef_q.pop_front();
          if (e !== out_data_i) begin
            fail_count_o <= fail_count_o + 1;
            if (e.coef_b0 !== out_data_i.coef_b0)
              $error("coef_b0 exp %0d got %0d", e.coef_b0, out_data_i.coef_b0);
            if (e.coef_b1 !== out_data_i.coef_b1)
              $error("coef_b1 exp %0d got %0d", e.coef_b1, out_data_i.coef_b1);
            if (e.coef_b2 !== out_data_i.coef_b2)
              $error("coef_b2 exp %0d got %0d", e.coef_b2, out_data_i.coef_b2);
            if (e.coef_a1 !== out_data_i.coef_a1)
              $error("coef_a1 exp %0d got %0d", e.coef_a1, out_data_i.coef_a1);
            if (e.coef_a2 !== out_data_i.coef_a2)
              $error("coef_a2 exp %0d got %0d", e.coef_a2, out_data_i.coef_a2);
            if (e.error_flag !== out_data_i.error_flag)
              $error("error_flag exp %0b got %0b", e.error_flag, out_data_i.error_flag);
          end
        end
      end
    end
  end

endmodule

// ===== test/biquad_coefficient_designer_top_test.sv =====
module biquad_coefficient_designer_top_test;
  import bqcd_pkg::*;

  logic clk, rst_n, in_valid, in_stall, out_valid, out_stall;
  in_t  in_data;
  out_t out_data;
  int   fail_count, pending, results;
  int   send_idle_pct, stall_pct, sent;
  logic hold_off;

  biquad_coefficient_designer_top DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data)
  );

  biquad_coefficient_designer_checker checker_i (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .fail_count_o(fail_count), .pending_o(pending), .results_o(results)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("biquad_coefficient_designer_top: mismatch");
    $finish;
  end

  always @(negedge clk) begin
    out_stall <= hold_off || ($urandom_range(99) < stall_pct);
  end

  function automatic in_t rand_req();
    in_t d;
    int sel;
    d.filter_kind = 2'($urandom_range(3));
    d.sample_rate_hz = 18'($urandom);
    d.quality_q8 = 16'($urandom);
    d.cutoff_hz = 18'($urandom);
    sel = $urandom_range(99);
    if (sel < 10) begin
      d.filter_kind = KIND_INVALID;
    end else begin
      if (d.filter_kind == KIND_INVALID) d.filter_kind = 2'($urandom_range(2));
      if (d.sample_rate_hz < 2) d.sample_rate_hz = 18'(2 + $urandom_range(1000));
      if (d.quality_q8 == 0) d.quality_q8 = 16'd1;
      if (sel < 15) d.sample_rate_hz = '0;
      else if (sel < 20) d.quality_q8 = '0;
      else if (sel < 30)
        d.cutoff_hz = 18'((d.sample_rate_hz + 1) / 2 + $urandom_range(7));
      else if (sel < 40)
        d.cutoff_hz = 18'((d.sample_rate_hz - 1) / 2 - $urandom_range(3));
      else if (sel < 45) d.quality_q8 = 16'($urandom_range(3) + 1);
      else d.cutoff_hz = 18'($urandom_range((d.sample_rate_hz - 1) / 2));
    end
    return d;
  endfunction

  task automatic offer(in_t d);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  task automatic req(logic [1:0] k, int f0, int fs, int q);
    in_t d;
    d.filter_kind = k;
    d.cutoff_hz = 18'(f0);
    d.sample_rate_hz = 18'(fs);
    d.quality_q8 = 16'(q);
    offer(d);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    hold_off = 1'b0;
    send_idle_pct = 0;
    stall_pct = 0;
    sent = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    req(KIND_LOWPASS, 1000, 48000, 181);
    req(KIND_BANDPASS, 1000, 48000, 181);
    req(KIND_HIGHPASS, 1000, 48000, 181);
    req(KIND_INVALID, 1000, 48000, 181);
    req(KIND_LOWPASS, 0, 48000, 256);
    req(KIND_HIGHPASS, 0, 1, 256);
    req(KIND_LOWPASS, 1000, 0, 256);
    req(KIND_LOWPASS, 1000, 48000, 0);
    req(KIND_LOWPASS, 24000, 48000, 256);
    req(KIND_LOWPASS, 23999, 48000, 65535);
    req(KIND_BANDPASS, 23999, 48000, 1);
    req(KIND_HIGHPASS, 23999, 48000, 65535);
    req(KIND_LOWPASS, 131070, 262143, 65535);
    req(KIND_HIGHPASS, 131071, 262143, 1);
    req(KIND_BANDPASS, 65535, 262143, 256);
    req(KIND_LOWPASS, 1, 262143, 65535);
    req(KIND_HIGHPASS, 12000, 48000, 256);
    req(KIND_INVALID, 262143, 262143, 65535);
    req(KIND_LOWPASS, 262143, 262143, 65535);
    req(KIND_BANDPASS, 0, 3, 1);

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        1: send_idle_pct = 67;
        2: stall_pct = 67;
        3: begin send_idle_pct = 15; stall_pct = 15; end
        4: begin send_idle_pct = 0; stall_pct = 0; end
        default: ;
      endcase
      if (ph == 4) begin
        fork
          begin
            hold_off = 1'b1;
            repeat (400) @(negedge clk);
            hold_off = 1'b0;
          end
          repeat (300) offer(rand_req());
        join
      end else begin
        repeat (300) offer(rand_req());
      end
      in_valid <= 1'b0;
      while (pending != 0) @(posedge clk);
    end

    repeat (150) @(posedge clk);
    $display("Sent %0d coefficient requests; %0d results checked across idle/stall phases.",
             sent, results);
    if (fail_count == 0 && pending == 0) begin
      $display("biquad_coefficient_designer_top: match");
    end else begin
      $display("biquad_coefficient_designer_top: mismatch");
    end
    $finish;
  end

endmodule

// ===== biquad_coefficient_designer_top.f =====
rtl/core/bqcd_pkg.sv
rtl/core/bqcd_div.sv
rtl/core/biquad_coefficient_designer_top.sv
test/biquad_coefficient_designer_checker.sv
test/biquad_coefficient_designer_top_test.sv
